// ----- design/rrts_pkg.sv -----
// Shared types and constants for the round-robin time-slice scheduler.
// Request/response payload structs, operation codes and the cell control bundle.
// No dependencies.
package rrts_pkg;

	localparam int ID_FIELD_W  = 8;
	localparam int ID_W_MAX    = 16;
	localparam int LEN_W_MAX   = 9;
	localparam int SLICE_W     = 32;
	localparam int QCOUNT_W    = 5;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 32'd1000;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DECIDE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_ASSIGN  = 2'd1,
		DEC_PREEMPT = 2'd2
	} decision_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		op_t                   operation;
		logic [ID_FIELD_W-1:0] task_id;
		logic                  running_valid;
		logic [ID_FIELD_W-1:0] running_id;
	} sched_req_t;

	typedef struct packed {
		decision_t             decision;
		logic [ID_FIELD_W-1:0] assign_id;
		logic [ID_FIELD_W-1:0] resign_id;
		logic [SLICE_W-1:0]    time_left;
		logic                  slice_pending;
		logic [QCOUNT_W-1:0]   queue_count;
		status_t               status;
	} sched_rsp_t;

	// control broadcast to every queue cell
	typedef struct packed {
		logic                 en;
		logic                 shift_all;
		logic                 remove;
		logic                 load;
		logic [LEN_W_MAX-1:0] wr_pos;
		logic [LEN_W_MAX-1:0] len;
		logic [ID_W_MAX-1:0]  key;
		logic [ID_W_MAX-1:0]  load_id;
	} cell_ctrl_t;

endpackage

// ----- design/rrts_cell.sv -----
// One entry of the ready queue: holds an id, matches it against a remove key,
// and either loads a new id or takes its right neighbor's id. Uses rrts_pkg.
module rrts_cell import rrts_pkg::*; #(
	parameter int IDX     = 0,
	parameter int ID_BITS = 8,
	parameter int LEN_W   = 5
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic [ID_BITS-1:0] next_id,
	input  logic               found_in,
	output logic [ID_BITS-1:0] id,
	output logic               found_out
);

	logic [ID_BITS-1:0] id_q;
	logic               occupied;
	logic               match;
	logic               load_here;

	assign occupied  = LEN_W'(IDX) < ctrl.len[LEN_W-1:0];
	assign match     = ctrl.remove && occupied && (id_q == ctrl.key[ID_BITS-1:0]);
	assign found_out = found_in | match;
	assign load_here = ctrl.load && (ctrl.wr_pos[LEN_W-1:0] == LEN_W'(IDX));
	assign id        = id_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (load_here) begin
				id_q <= ctrl.load_id[ID_BITS-1:0];
			end else if (ctrl.shift_all || found_out) begin
				id_q <= next_id;
			end
		end
	end

endmodule

// ----- design/round_robin_timeslice_scheduler.sv -----
// Round-robin time-slice scheduler: one request is taken per clock cycle while
// req_stall is low, and its response appears in an output register on the next
// cycle. The ready queue is a row of QUEUE_DEPTH cells; add, remove-and-collapse,
// pop and preempt-to-tail all finish as the request is taken, the remove match rippling
// through the cell row. The queue needs no clearing after reset. Built from rrts_cell; uses rrts_pkg.
module round_robin_timeslice_scheduler import rrts_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  sched_req_t         req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sched_rsp_t         rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SLICE_W-1:0] cfg_data
);

	localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

	logic [SLICE_W-1:0] time_slice_q;
	logic [SLICE_W-1:0] slice_q;
	logic [LEN_W-1:0]   len_q;
	logic               rsp_valid_q;
	sched_rsp_t         rsp_q;

	logic               accept;
	logic [ID_W_MAX-1:0] tid_ext;
	logic [ID_W_MAX-1:0] rid_ext;
	logic [ID_W_MAX-1:0] head_ext;
	logic [ID_BITS-1:0] tid;
	logic [ID_BITS-1:0] rid;
	logic               full;
	logic               nonempty;
	logic               expired;
	logic               do_pop;
	logic               preempt;
	logic               do_add;
	logic               found;
	logic [SLICE_W-1:0] slice_d;
	logic [LEN_W-1:0]   len_d;
	sched_rsp_t         rsp_d;
	cell_ctrl_t         ctrl;

	logic [ID_BITS-1:0] ids   [QUEUE_DEPTH];
	logic               chain [QUEUE_DEPTH+1];

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign tid_ext  = ID_W_MAX'(req.task_id);
	assign rid_ext  = ID_W_MAX'(req.running_id);
	assign tid      = tid_ext[ID_BITS-1:0];
	assign rid      = rid_ext[ID_BITS-1:0];
	assign head_ext = ID_W_MAX'(ids[0]);

	assign full     = len_q == LEN_W'(QUEUE_DEPTH);
	assign nonempty = len_q != '0;
	assign expired  = slice_q == '0;
	assign do_add   = (req.operation == OP_ADD) && !full;
	assign do_pop   = (req.operation == OP_DECIDE) && nonempty &&
	                  (expired || !req.running_valid);
	assign preempt  = do_pop && expired && req.running_valid;
	assign found    = chain[QUEUE_DEPTH];

	always_comb begin
		ctrl           = '0;
		ctrl.en        = accept;
		ctrl.shift_all = do_pop;
		ctrl.remove    = req.operation == OP_REMOVE;
		ctrl.load      = do_add || preempt;
		ctrl.wr_pos    = preempt ? LEN_W_MAX'(len_q - LEN_W'(1)) : LEN_W_MAX'(len_q);
		ctrl.len       = LEN_W_MAX'(len_q);
		ctrl.key       = ID_W_MAX'(tid);
		ctrl.load_id   = preempt ? ID_W_MAX'(rid) : ID_W_MAX'(tid);
	end

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0] nbr;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nbr = ids[i];
		end else begin : g_mid
			assign nbr = ids[i+1];
		end
		rrts_cell #(
			.IDX     (i),
			.ID_BITS (ID_BITS),
			.LEN_W   (LEN_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.next_id   (nbr),
			.found_in  (chain[i]),
			.id        (ids[i]),
			.found_out (chain[i+1])
		);
	end

	always_comb begin
		slice_d = slice_q;
		len_d   = len_q;
		rsp_d   = '0;
		unique case (req.operation)
			OP_ADD: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					len_d = len_q + LEN_W'(1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					len_d = len_q - LEN_W'(1);
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			OP_DECIDE: begin
				if (do_pop) begin
					slice_d         = time_slice_q;
					rsp_d.assign_id = head_ext[ID_FIELD_W-1:0];
					if (preempt) begin
						rsp_d.decision  = DEC_PREEMPT;
						rsp_d.resign_id = rid_ext[ID_FIELD_W-1:0];
					end else begin
						rsp_d.decision = DEC_ASSIGN;
						len_d          = len_q - LEN_W'(1);
					end
				end
			end
			OP_TICK: begin
				if (!expired) begin
					slice_d = slice_q - SLICE_W'(1);
				end
			end
			default: begin
			end
		endcase
		rsp_d.time_left     = slice_d;
		rsp_d.queue_count   = QCOUNT_W'(len_d);
		rsp_d.slice_pending = (len_d == '0 && !req.running_valid) ? 1'b0 : (slice_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= SLICE_RESET;
			slice_q      <= '0;
			len_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				time_slice_q <= cfg_data;
			end
			if (accept) begin
				slice_q     <= slice_d;
				len_q       <= len_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(QUEUE_DEPTH))
		else $error("queue length above depth");

	a_preempt_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && preempt |=> $stable(len_q))
		else $error("preempt changed queue length");

	a_pop_reload: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_pop |=> slice_q == $past(time_slice_q))
		else $error("slice not reloaded on assign");

endmodule

// ----- tb/sv/rrts_response_checker.sv -----
// Response checker for the round-robin time-slice scheduler: watches the request,
// response and slice-length channels, predicts each response and compares it.
// Depends on rrts_pkg for the payload types and codes.
module rrts_response_checker import rrts_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  sched_req_t         req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  sched_rsp_t         rsp,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [SLICE_W-1:0] cfg_data,
	output int unsigned        error_count,
	output int unsigned        checked_count,
	output int unsigned        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ID_FIELD_W-1:0] ID_MASK = ID_FIELD_W'((1 << ID_BITS) - 1);

	logic [ID_FIELD_W-1:0] ready_ids [QUEUE_DEPTH];
	int unsigned           ready_len;
	logic [SLICE_W-1:0]    slice_len;
	logic [SLICE_W-1:0]    slice_left;
	sched_rsp_t            expected_rsp_q [$];
	sched_rsp_t            want;

	function automatic bit push_id(logic [ID_FIELD_W-1:0] id);
		if (ready_len >= QUEUE_DEPTH)
			return 1'b0;
		ready_ids[ready_len] = id;
		ready_len++;
		return 1'b1;
	endfunction

	function automatic logic [ID_FIELD_W-1:0] pop_id();
		logic [ID_FIELD_W-1:0] head;
		head = ready_ids[0];
		for (int i = 1; i < ready_len; i++)
			ready_ids[i - 1] = ready_ids[i];
		ready_len--;
		slice_left = slice_len;
		return head;
	endfunction

	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t            o;
		logic [ID_FIELD_W-1:0] tid;
		logic [ID_FIELD_W-1:0] rid;
		bit                    found;
		o = '0;
		o.decision = DEC_NONE;
		o.status = ST_OK;
		tid = r.task_id & ID_MASK;
		rid = r.running_id & ID_MASK;
		found = 1'b0;
		case (r.operation)
			OP_ADD: begin
				if (!push_id(tid))
					o.status = ST_FULL;
			end
			OP_REMOVE: begin
				for (int i = 0; i < ready_len && !found; i++) begin
					if (ready_ids[i] == tid) begin
						found = 1'b1;
						for (int j = i + 1; j < ready_len; j++)
							ready_ids[j - 1] = ready_ids[j];
						ready_len--;
					end
				end
				if (!found)
					o.status = ST_NOT_FOUND;
			end
			OP_DECIDE: begin
				if (slice_left == '0) begin
					if (ready_len > 0) begin
						o.assign_id = pop_id();
						o.decision = DEC_ASSIGN;
						if (r.running_valid) begin
							// preempted task goes back to the tail; the pop made room
							o.resign_id = rid;
							void'(push_id(rid));
							o.decision = DEC_PREEMPT;
						end
					end
				end else if (!r.running_valid && ready_len > 0) begin
					o.assign_id = pop_id();
					o.decision = DEC_ASSIGN;
				end
			end
			default: begin
				if (slice_left != '0)
					slice_left--;
			end
		endcase
		o.time_left = slice_left;
		o.slice_pending = (ready_len == 0 && !r.running_valid) ? 1'b0 : (slice_left != '0);
		o.queue_count = QCOUNT_W'(ready_len);
		return o;
	endfunction

	function automatic void check_field(string name, logic [SLICE_W-1:0] exp_val,
			logic [SLICE_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_len = SLICE_RESET;
			slice_left = '0;
			ready_len = 0;
			expected_rsp_q.delete();
			error_count = 0;
			checked_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				slice_len = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with no request outstanding");
					error_count++;
				end else begin
					want = expected_rsp_q[0];
					expected_rsp_q.delete(0);
					check_field("decision", SLICE_W'(want.decision), SLICE_W'(rsp.decision));
					check_field("assign_id", SLICE_W'(want.assign_id), SLICE_W'(rsp.assign_id));
					check_field("resign_id", SLICE_W'(want.resign_id), SLICE_W'(rsp.resign_id));
					check_field("time_left", want.time_left, rsp.time_left);
					check_field("slice_pending", SLICE_W'(want.slice_pending),
						SLICE_W'(rsp.slice_pending));
					check_field("queue_count", SLICE_W'(want.queue_count),
						SLICE_W'(rsp.queue_count));
					check_field("status", SLICE_W'(want.status), SLICE_W'(rsp.status));
					checked_count++;
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.insert(expected_rsp_q.size(), schedule_step(req));
		end
		outstanding = expected_rsp_q.size();
	end

endmodule

// ----- tb/sv/round_robin_timeslice_scheduler_test.sv -----
// Top of the scheduler testbench: clock, reset, request and slice-length stimulus,
// response-side stalls and the verdict. Uses rrts_pkg and rrts_response_checker.
module round_robin_timeslice_scheduler_test import rrts_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH           = 16;
	localparam int IDW             = 8;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 172;
	localparam int LONG_HOLD       = 64;
	localparam int POOL_SIZE       = 6;
	localparam int DRAIN_CYCLES    = 10;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	sched_req_t         req;
	logic               rsp_valid;
	logic               rsp_stall;
	sched_rsp_t         rsp;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SLICE_W-1:0] cfg_data;

	int unsigned error_count;
	int unsigned checked_count;
	int unsigned outstanding;

	bit                    send_gaps_on;
	bit                    recv_gaps_on;
	bit                    long_hold;
	int unsigned           add_weight;
	int unsigned           op_count [4];
	logic [ID_FIELD_W-1:0] id_pool [POOL_SIZE];

	round_robin_timeslice_scheduler #(.QUEUE_DEPTH(DEPTH), .ID_BITS(IDW)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rrts_response_checker #(.QUEUE_DEPTH(DEPTH), .ID_BITS(IDW)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.error_count(error_count), .checked_count(checked_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic sched_req_t make_req(op_t op, logic [ID_FIELD_W-1:0] tid,
			logic run_valid, logic [ID_FIELD_W-1:0] run_id);
		sched_req_t r;
		r.operation = op;
		r.task_id = tid;
		r.running_valid = run_valid;
		r.running_id = run_id;
		return r;
	endfunction

	function automatic logic [ID_FIELD_W-1:0] pick_id();
		if ($urandom_range(0, 4) == 0)
			return ID_FIELD_W'($urandom);
		return id_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic sched_req_t random_request();
		int unsigned pick;
		op_t         op;
		pick = $urandom_range(0, 99);
		if (pick < add_weight)
			op = OP_ADD;
		else if (pick < add_weight + 20)
			op = OP_REMOVE;
		else if (pick < add_weight + 45)
			op = OP_DECIDE;
		else
			op = OP_TICK;
		return make_req(op, pick_id(), 1'($urandom_range(0, 1)), pick_id());
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(sched_req_t r);
		int unsigned gap;
		gap = send_gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		op_count[r.operation]++;
		@(negedge clk);
	endtask

	initial begin : response_side
		int unsigned hold;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold)
				hold = LONG_HOLD;
			else
				hold = recv_gaps_on ? $urandom_range(0, 8) : 0;
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				long_hold = 1'b0;
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
		long_hold = 1'b0;
		add_weight = 30;
		foreach (op_count[k])
			op_count[k] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty queue, missing id, tick at zero, fill to full, preempt
		send_request(make_req(OP_DECIDE, 8'h00, 1'b0, 8'h00));
		send_request(make_req(OP_DECIDE, 8'h00, 1'b1, 8'hFF));
		send_request(make_req(OP_REMOVE, 8'h00, 1'b0, 8'h00));
		send_request(make_req(OP_TICK, 8'hFF, 1'b1, 8'hFF));
		for (int i = 0; i < DEPTH; i++)
			send_request(make_req(OP_ADD, ID_FIELD_W'(i * 17), 1'b0, 8'h00));
		send_request(make_req(OP_ADD, 8'h42, 1'b0, 8'h00));
		send_request(make_req(OP_DECIDE, 8'h00, 1'b1, 8'hAA));
		send_request(make_req(OP_DECIDE, 8'h00, 1'b0, 8'h55));
		send_request(make_req(OP_DECIDE, 8'h00, 1'b1, 8'h55));
		send_request(make_req(OP_REMOVE, 8'h77, 1'b0, 8'h00));
		send_request(make_req(OP_TICK, 8'h00, 1'b0, 8'h00));

		for (int p = 0; p < PHASES; p++) begin
			req_valid <= 1'b0;
			wait (outstanding == 0);
			@(negedge clk);
			cfg_valid <= 1'b1;
			if (p == 0)
				cfg_data <= 32'd1;
			else if (p == 1)
				cfg_data <= 32'hFFFF_FFFF;
			else if (p == 2)
				cfg_data <= 32'd0;
			else
				cfg_data <= SLICE_W'($urandom_range(1, 16));
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
			cfg_valid <= 1'b0;
			foreach (id_pool[k])
				id_pool[k] = ID_FIELD_W'($urandom);
			add_weight = $urandom_range(20, 45);
			send_gaps_on = (p != 4) && (p != 7);
			recv_gaps_on = (p != 7) && (p != 8);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 4 && n == 40)
					long_hold = 1'b1;
				if (p == 6 && n == ITEMS_PER_PHASE / 2) begin
					req_valid <= 1'b0;
					wait (outstanding == 0);
					@(negedge clk);
				end
				send_request(random_request());
			end
		end
		req_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Run covered %0d requests: %0d add, %0d remove, %0d decide, %0d tick.",
			op_count[OP_ADD] + op_count[OP_REMOVE] + op_count[OP_DECIDE] + op_count[OP_TICK],
			op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_DECIDE], op_count[OP_TICK]);
		$display("%0d responses compared over %0d slice lengths, including 0, 1 and max.",
			checked_count, PHASES + 1);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
